// File: rtl/bjd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bjd_pkg: shared types and constants for the bitset Jaccard distance unit
// Word layouts of both channels, count bounds, widths of the divider and
// the byte popcount used by the counting loop.
// ----------------------------------------------------------------------------
package bjd_pkg;

  // Longest pair of bitsets, in 64-bit storage words, counted without saturation.
  localparam int MAX_WORDS = 4096;

  localparam int WORD_W  = 64;
  localparam int CNT_W   = 19;
  localparam int FRAC_W  = 16;
  localparam int DIST_W  = FRAC_W + 1;
  localparam int NUM_W   = CNT_W + FRAC_W;
  localparam int STEP_W  = $clog2(NUM_W);

  // Popcount is done one byte at a time.
  localparam int CHUNK_W   = 8;
  localparam int CHUNKS    = WORD_W / CHUNK_W;
  localparam int CHUNK_IDX = $clog2(CHUNKS);
  localparam int PC_W      = $clog2(CHUNK_W + 1);

  // Saturation bound of both counts: MAX_WORDS*64, capped to the field width.
  localparam longint COUNT_BOUND = longint'(MAX_WORDS) * WORD_W;
  localparam longint CNT_LIMIT   = (longint'(1) << CNT_W) - 1;
  localparam logic [CNT_W-1:0] COUNT_MAX =
    CNT_W'((COUNT_BOUND < CNT_LIMIT) ? COUNT_BOUND : CNT_LIMIT);

  // 1.0 in Q1.16.
  localparam logic [DIST_W-1:0] Q16_ONE = DIST_W'(1) << FRAC_W;

  typedef struct packed {
    logic [WORD_W-1:0] word_a;
    logic [WORD_W-1:0] word_b;
    logic              last_word;
  } in_word_t;

  typedef struct packed {
    logic [CNT_W-1:0]  intersection_count;
    logic [CNT_W-1:0]  union_count;
    logic [DIST_W-1:0] distance_q16;
    logic              empty_union;
  } out_word_t;

  // Divider handshake between the sequencer and the divide unit.
  typedef struct packed {
    logic start;
  } div_ctrl_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

  // Number of set bits in one byte.
  function automatic logic [PC_W-1:0] popcount_chunk(input logic [CHUNK_W-1:0] v);
    logic [PC_W-1:0] n;
    n = '0;
    for (int i = 0; i < CHUNK_W; i++) begin
      n = n + PC_W'(v[i]);
    end
    return n;
  endfunction

endpackage

// File: rtl/bitset_jaccard_distance_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bitset_jaccard_distance_unit: streamed Jaccard distance of two bitsets
// Counts the set bits of AND and OR of each pair of storage words and, on
// the last word, reports both counts and 1 - intersection/union in Q1.16.
//
//   channel | handshake           | word        | direction
//   --------+---------------------+-------------+----------
//   in      | in_valid / in_ready | in_data     | into block
//   out     | out_valid/out_ready | out_data    | out of block
//
// Every word is accepted from idle and then passes, byte by byte, through the shared
// byte popcount and saturating adder, one byte of AND and OR per cycle.
// A last word then goes through a setup state, the one-bit-per-cycle divider
// (skipped for an empty union), collection of the quotient and the load of the output register.
// in_ready is high only while the sequencer is idle; a stalled output holds
// the result and the block waits to deliver before clearing its counts.
// Synchronous reset clears both counts, the sequencer and out_valid.
// ----------------------------------------------------------------------------
module bitset_jaccard_distance_unit (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  bjd_pkg::in_word_t   in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output bjd_pkg::out_word_t  out_data
);

  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_COUNT  = 3'd1;
  localparam logic [2:0] ST_PREP   = 3'd2;
  localparam logic [2:0] ST_DIVIDE = 3'd3;
  localparam logic [2:0] ST_FINISH = 3'd4;

  logic [2:0]                       state;
  logic [bjd_pkg::CHUNK_IDX-1:0]    chunk;
  logic [bjd_pkg::WORD_W-1:0]       and_sh;
  logic [bjd_pkg::WORD_W-1:0]       or_sh;
  logic                             last_r;
  logic [bjd_pkg::CNT_W-1:0]        inter_acc;
  logic [bjd_pkg::CNT_W-1:0]        union_acc;
  logic [bjd_pkg::DIST_W-1:0]       dist_r;
  logic                             empty_r;

  logic [bjd_pkg::PC_W-1:0]         pc_and;
  logic [bjd_pkg::PC_W-1:0]         pc_or;
  logic [bjd_pkg::CNT_W:0]          sum_inter;
  logic [bjd_pkg::CNT_W:0]          sum_union;
  logic [bjd_pkg::CNT_W-1:0]        inter_next;
  logic [bjd_pkg::CNT_W-1:0]        union_next;

  logic [bjd_pkg::CNT_W-1:0]        inter_clamp;
  logic [bjd_pkg::CNT_W-1:0]        gap;
  logic [bjd_pkg::NUM_W-1:0]        numerator;

  bjd_pkg::div_ctrl_t               div_ctrl;
  bjd_pkg::div_stat_t               div_stat;
  logic [bjd_pkg::DIST_W-1:0]       quotient;

  assign in_ready = (state == ST_IDLE);

  // Shared popcount and saturating add on the current byte.
  always_comb begin
    pc_and     = bjd_pkg::popcount_chunk(and_sh[bjd_pkg::CHUNK_W-1:0]);
    pc_or      = bjd_pkg::popcount_chunk(or_sh[bjd_pkg::CHUNK_W-1:0]);
    sum_inter  = {1'b0, inter_acc} + (bjd_pkg::CNT_W + 1)'(pc_and);
    sum_union  = {1'b0, union_acc} + (bjd_pkg::CNT_W + 1)'(pc_or);
    inter_next = (sum_inter > {1'b0, bjd_pkg::COUNT_MAX}) ? bjd_pkg::COUNT_MAX
                                                          : sum_inter[bjd_pkg::CNT_W-1:0];
    union_next = (sum_union > {1'b0, bjd_pkg::COUNT_MAX}) ? bjd_pkg::COUNT_MAX
                                                          : sum_union[bjd_pkg::CNT_W-1:0];
  end

  // Dividend of the rounded distance: (union - inter) * 2^16 + union / 2.
  always_comb begin
    inter_clamp = (inter_acc > union_acc) ? union_acc : inter_acc;
    gap         = union_acc - inter_clamp;
    numerator   = {gap, bjd_pkg::FRAC_W'(0)}
                + bjd_pkg::NUM_W'(union_acc >> 1);
  end

  assign div_ctrl.start = (state == ST_PREP) && (union_acc != '0);

  bjd_divider u_div (
    .clk       (clk),
    .rst       (rst),
    .ctrl      (div_ctrl),
    .numerator (numerator),
    .divisor   (union_acc),
    .stat      (div_stat),
    .quotient  (quotient)
  );

  // Sequencer, accumulators and output valid.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      chunk     <= '0;
      inter_acc <= '0;
      union_acc <= '0;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (in_valid) begin
            chunk <= '0;
            state <= ST_COUNT;
          end
        end
        ST_COUNT: begin
          inter_acc <= inter_next;
          union_acc <= union_next;
          chunk     <= chunk + 1'b1;
          if (chunk == bjd_pkg::CHUNK_IDX'(bjd_pkg::CHUNKS - 1)) begin
            state <= last_r ? ST_PREP : ST_IDLE;
          end
        end
        ST_PREP: begin
          state <= (union_acc == '0) ? ST_FINISH : ST_DIVIDE;
        end
        ST_DIVIDE: begin
          if (div_stat.done) begin
            state <= ST_FINISH;
          end
        end
        ST_FINISH: begin
          if (!out_valid || out_ready) begin
            out_valid <= 1'b1;
            inter_acc <= '0;
            union_acc <= '0;
            state     <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // Word shift registers, distance and the output word.
  always_ff @(posedge clk) begin
    if (state == ST_IDLE && in_valid) begin
      and_sh <= in_data.word_a & in_data.word_b;
      or_sh  <= in_data.word_a | in_data.word_b;
      last_r <= in_data.last_word;
    end else if (state == ST_COUNT) begin
      and_sh <= and_sh >> bjd_pkg::CHUNK_W;
      or_sh  <= or_sh >> bjd_pkg::CHUNK_W;
    end
    if (state == ST_PREP) begin
      dist_r  <= '0;
      empty_r <= (union_acc == '0);
    end else if (state == ST_DIVIDE && div_stat.done) begin
      dist_r <= quotient;
    end
    if (state == ST_FINISH && (!out_valid || out_ready)) begin
      out_data.intersection_count <= inter_acc;
      out_data.union_count        <= union_acc;
      out_data.distance_q16       <= dist_r;
      out_data.empty_union        <= empty_r;
    end
  end

endmodule

// File: rtl/bjd_divider.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bjd_divider: restoring divider for the distance quotient
// One numerator bit per cycle through a single compare and subtract. Only
// the low DIST_W quotient bits are kept, since the quotient never exceeds 1.0.
// ----------------------------------------------------------------------------
module bjd_divider (
  input  logic                            clk,
  input  logic                            rst,
  input  bjd_pkg::div_ctrl_t              ctrl,
  input  logic [bjd_pkg::NUM_W-1:0]       numerator,
  input  logic [bjd_pkg::CNT_W-1:0]       divisor,
  output bjd_pkg::div_stat_t              stat,
  output logic [bjd_pkg::DIST_W-1:0]      quotient
);

  logic                          busy;
  logic                          done;
  logic [bjd_pkg::STEP_W-1:0]    step;
  logic [bjd_pkg::NUM_W-1:0]     num_sh;
  logic [bjd_pkg::CNT_W-1:0]     rem;
  logic [bjd_pkg::CNT_W-1:0]     div_r;
  logic [bjd_pkg::DIST_W-1:0]    quo;

  logic [bjd_pkg::CNT_W:0]       trial;
  logic [bjd_pkg::CNT_W:0]       diff;
  logic                          fits;
  logic [bjd_pkg::CNT_W-1:0]     rem_next;
  logic [bjd_pkg::DIST_W-1:0]    quo_next;

  // Shared compare and subtract: bring down the next numerator bit.
  always_comb begin
    trial    = {rem, num_sh[bjd_pkg::NUM_W-1]};
    fits     = trial >= {1'b0, div_r};
    diff     = trial - {1'b0, div_r};
    rem_next = fits ? diff[bjd_pkg::CNT_W-1:0] : trial[bjd_pkg::CNT_W-1:0];
    quo_next = {quo[bjd_pkg::DIST_W-2:0], fits};
  end

  // Step counter and completion pulse.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      step <= '0;
    end else begin
      done <= 1'b0;
      if (ctrl.start) begin
        busy <= 1'b1;
        step <= '0;
      end else if (busy) begin
        step <= step + 1'b1;
        if (step == bjd_pkg::STEP_W'(bjd_pkg::NUM_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // Datapath registers of the division.
  always_ff @(posedge clk) begin
    if (ctrl.start) begin
      num_sh <= numerator;
      rem    <= '0;
      div_r  <= divisor;
      quo    <= '0;
    end else if (busy) begin
      num_sh <= {num_sh[bjd_pkg::NUM_W-2:0], 1'b0};
      rem    <= rem_next;
      quo    <= quo_next;
    end
  end

  assign stat.busy = busy;
  assign stat.done = done;
  assign quotient  = quo;

endmodule

// File: rtl/bjd_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bjd_checker: port-level checks for the bitset Jaccard distance unit
// Watches the input channel for the busy period after an accepted word, the
// result channel for a held word under stall, and the consistency between
// the counts, the distance and the empty flag.
// ----------------------------------------------------------------------------
module bjd_checker (
  input logic                clk,
  input logic                rst,
  input logic                in_valid,
  input logic                in_ready,
  input logic                out_valid,
  input logic                out_ready,
  input bjd_pkg::out_word_t  out_data
);

  // An accepted input word keeps the block busy for the next cycle.
  a_in_busy: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("input ready right after an accepted word");

  // A stalled result word stays put.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result word changed while stalled");

  // An empty union reports zero counts and zero distance.
  a_empty: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.empty_union |->
      out_data.union_count == '0 && out_data.distance_q16 == '0 &&
      out_data.intersection_count == '0)
    else $error("empty union with nonzero fields");

  // A non-empty result has a union count.
  a_nonempty: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_data.empty_union |-> out_data.union_count != '0)
    else $error("empty flag clear with zero union");

  // The intersection never exceeds the union, and the distance never exceeds 1.0.
  a_bounds: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> out_data.intersection_count <= out_data.union_count &&
                  out_data.distance_q16 <= bjd_pkg::Q16_ONE)
    else $error("result fields out of range");

endmodule

bind bitset_jaccard_distance_unit bjd_checker u_bjd_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);
